>>> design/lru_page_replacement_core_assert.svh
// assertion macros for the lru page replacement core
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LRU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LRU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lru_pkg.sv
// shared types and constants for the lru page replacement core
package lru_pkg;

  localparam int DEF_MAX_FRAMES = 8;
  localparam int DEF_PAGE_BITS  = 16;

  localparam int ACTIVE_W     = 4;
  localparam int STAMP_W      = 32;
  localparam int COUNT_W      = 32;
  localparam int FRAME_USED_W = 3;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

>>> design/lru_page_replacement_core.sv
// lru page replacement core: top level with frame scan control
//
// Each item is one page reference. The core walks the active frames through
// its frame memory one entry per cycle (single read port, registered read),
// finds a hit or picks the victim (first empty frame, else smallest stamp,
// lowest index on ties), then writes the frame back and pulses done with the
// result for one cycle. The scan covers the frames in use (active_frames held
// to 1..MAX_FRAMES); busy drops in the done cycle so the next item can be
// accepted there. The result is not held for the receiver: it must take it in
// the done cycle. end_of_string clears frames and counters right after its
// own result.
`include "lru_page_replacement_core_assert.svh"

module lru_page_replacement_core
  import lru_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [PAGE_BITS-1:0]    page,
  input  logic                    end_of_string,
  input  logic                    cfg_we,
  input  logic [ACTIVE_W-1:0]     cfg_wdata,
  output logic                    done,
  output logic                    hit,
  output logic [FRAME_USED_W-1:0] frame_used,
  output logic                    evicted_valid,
  output logic [PAGE_BITS-1:0]    evicted_page,
  output logic [COUNT_W-1:0]      hit_count,
  output logic [COUNT_W-1:0]      fault_count,
  output logic                    last
);

  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int ENTRY_W    = PAGE_BITS + STAMP_W;
  localparam int SLOT_EXT_W = IDX_W + FRAME_USED_W;

  state_t state, state_next;

  logic [ACTIVE_W-1:0]   active_frames;
  logic [CNT_W-1:0]      used;
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [STAMP_W-1:0]    access_number;
  logic [COUNT_W-1:0]    hits_so_far, hits_next;
  logic [COUNT_W-1:0]    faults_so_far, faults_next;

  logic [PAGE_BITS-1:0]  page_q;
  logic                  eos_q;

  logic [CNT_W-1:0]      issue_cnt;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [STAMP_W-1:0]    min_stamp;
  logic [IDX_W-1:0]      min_idx;
  logic [PAGE_BITS-1:0]  min_page;

  logic                  scan_issue;
  logic                  scan_end;
  logic                  mem_we;
  logic [ENTRY_W-1:0]    rd_data;
  logic [PAGE_BITS-1:0]  rd_page;
  logic [STAMP_W-1:0]    rd_stamp;

  logic                  empty_found;
  logic [IDX_W-1:0]      empty_idx;
  logic [IDX_W-1:0]      slot;
  logic                  evict;
  logic [SLOT_EXT_W-1:0] slot_ext;

  // frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    if (active_frames == '0) begin
      used = CNT_W'(1);
    end else if (32'(active_frames) > MAX_FRAMES) begin
      used = CNT_W'(MAX_FRAMES);
    end else begin
      used = CNT_W'(active_frames);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_frames <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control outputs per state
  always_comb begin
    busy       = 1'b1;
    scan_issue = 1'b0;
    mem_we     = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: scan_issue = (issue_cnt < used);
      ST_DONE: mem_we = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign scan_end = (issue_cnt == used) && !pend;
  assign rd_page  = rd_data[STAMP_W +: PAGE_BITS];
  assign rd_stamp = rd_data[STAMP_W-1:0];

  // frame table
  lru_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (ENTRY_W)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (slot),
    .wr_data ({page_q, access_number}),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // latch the item on accept
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      page_q <= page;
      eos_q  <= end_of_string;
    end
  end

  // scan: issue one read per cycle, evaluate each entry when its registered read data returns
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
      hit_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
      hit_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      pend <= scan_issue;
      if (scan_issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
        pend_idx  <= issue_cnt[IDX_W-1:0];
      end
      if (pend) begin
        if (!hit_found && frame_valid[pend_idx] && rd_page == page_q) begin
          hit_found <= 1'b1;
          hit_idx   <= pend_idx;
        end
        if (pend_idx == '0 || rd_stamp < min_stamp) begin
          min_stamp <= rd_stamp;
          min_idx   <= pend_idx;
          min_page  <= rd_page;
        end
      end
    end
  end

  // lowest empty frame among the active ones
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (32'(k) < 32'(used) && !frame_valid[k]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(k);
      end
    end
  end

  // slot choice and counter updates
  always_comb begin
    evict       = !hit_found && !empty_found;
    hits_next   = hits_so_far;
    faults_next = faults_so_far;
    if (hit_found) begin
      slot = hit_idx;
      if (hits_so_far != '1) hits_next = hits_so_far + COUNT_W'(1);
    end else begin
      slot = empty_found ? empty_idx : min_idx;
      if (faults_so_far != '1) faults_next = faults_so_far + COUNT_W'(1);
    end
    slot_ext = SLOT_EXT_W'(slot);
  end

  // string state: valid bits, access number, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      access_number <= '0;
      hits_so_far   <= '0;
      faults_so_far <= '0;
    end else if (state == ST_DONE) begin
      if (eos_q) begin
        frame_valid   <= '0;
        access_number <= '0;
        hits_so_far   <= '0;
        faults_so_far <= '0;
      end else begin
        frame_valid[slot] <= 1'b1;
        access_number     <= access_number + STAMP_W'(1);
        hits_so_far       <= hits_next;
        faults_so_far     <= faults_next;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      hit           <= hit_found;
      frame_used    <= slot_ext[FRAME_USED_W-1:0];
      evicted_valid <= evict;
      evicted_page  <= evict ? min_page : '0;
      hit_count     <= hits_next;
      fault_count   <= faults_next;
      last          <= eos_q;
    end
  end

  // checks
  `LRU_ASSERT_NXT(a_done_after_write, state == ST_DONE, done && !busy, "done must follow write-back")
  `LRU_ASSERT_IMP(a_hit_no_evict, done, !(hit && evicted_valid), "hit item reports an eviction")
  `LRU_ASSERT_IMP(a_evict_page_zero, done && !evicted_valid, evicted_page == '0, "stale evicted page")
  `LRU_ASSERT_IMP(a_issue_bound, state == ST_SCAN, issue_cnt <= used, "scan ran past active frames")
  `LRU_ASSERT_NXT(a_accept_scan, start && !busy, state == ST_SCAN && issue_cnt == '0, "accept did not start scan")

endmodule

>>> design/lru_frame_mem.sv
// frame table memory: page and last-use stamp per frame, registered read
module lru_frame_mem
  import lru_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_FRAMES,
  parameter int WIDTH = DEF_PAGE_BITS + STAMP_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
